/* sv/affine_point_transform_classifier_defines.svh */
// Assertion macros for the affine point transform classifier.
// Used by the port checker; no other dependencies.
`ifndef AFFINE_POINT_TRANSFORM_CLASSIFIER_DEFINES_SVH
`define AFFINE_POINT_TRANSFORM_CLASSIFIER_DEFINES_SVH

// Same-edge implication, disabled while reset is high.
`define APT_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("apt check failed");

// Plain condition, checked at every edge out of reset.
`define APT_ASSERT_ALWAYS(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond)) \
    else $error("apt check failed");

`endif

/* sv/apt_pkg.sv */
// Shared types and constants for the affine point transform classifier.
// No dependencies.
`timescale 1ns / 1ps

package apt_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;

  localparam int unsigned DATA_W = 32;

  // Reset values of the matrix registers (identity, no offset)
  localparam logic signed [DATA_W-1:0] COEF_UNIT_RST = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] COEF_ZERO_RST = 32'sh0000_0000;

  // Width of the exact dot product sum, covers FRAC_BITS up to 24
  localparam int unsigned SUM_W = 66;

  typedef struct packed {
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
  } point_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] mapped_x;
    logic signed [DATA_W-1:0] mapped_y;
    logic                     saturated;
    logic [3:0]               kind_bits;
    logic [2:0]               orient_bits;
    logic                     orient_invalid;
    logic                     needs_filter;
  } result_t;

endpackage

/* sv/affine_point_transform_classifier.sv */
// Top level of the affine point transform classifier: config registers,
// multiply stage, sum/round/saturate stage and matrix classification.
// Depends on apt_pkg.
`timescale 1ns / 1ps

// Maps one Q(32-FRAC_BITS).FRAC_BITS point per clock through the matrix
// held in the six config registers. Drive start with a point while busy is
// low and the item is taken at that edge; a new item may follow in every
// cycle. Each item passes the input register, the register after the four
// 32x32 multipliers and the register after the wide add, round and
// saturate. Then done is high for exactly one cycle with the result on the
// result port, and it must be captured then, since there is no way to hold
// it. busy is set while reset is held, clears once reset is released, and
// stays low from then on. The classification fields depend only on the
// config registers; write them only when no item is in flight. A write to
// an index above five is dropped.
module affine_point_transform_classifier
  import apt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  point_t               point,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam logic signed [DATA_W-1:0] ONE     = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] NEG_ONE = -ONE;
  localparam logic signed [SUM_W-1:0]  HALF    = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] NEG_MAX = {1'b1, {(DATA_W-1){1'b0}}};

  // Matrix registers
  logic signed [DATA_W-1:0] coef_a, coef_b, coef_c, coef_d;
  logic signed [DATA_W-1:0] offset_x, offset_y;

  // Pipeline control and payload
  logic                     accept;
  logic                     in_valid;
  logic                     prod_valid;
  logic signed [DATA_W-1:0] px, py;
  logic signed [2*DATA_W-1:0] prod_ax, prod_by, prod_cx, prod_dy;

  // Sum stage
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic signed [SUM_W-1:0]  shr_x, shr_y;
  logic                     ovf_x, ovf_y;
  logic signed [DATA_W-1:0] sat_x, sat_y;

  // Classification
  logic       axis_aligned, rot_90, invalid, scale;
  logic [2:0] orient;
  logic [3:0] kind;

  assign accept = start && !busy;

  // Busy is set in reset and cleared once reset is released, so nothing is taken mid-clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Config writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a   <= COEF_UNIT_RST;
      coef_b   <= COEF_ZERO_RST;
      coef_c   <= COEF_ZERO_RST;
      coef_d   <= COEF_UNIT_RST;
      offset_x <= COEF_ZERO_RST;
      offset_y <= COEF_ZERO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_A:   coef_a   <= cfg_data;
        REG_COEF_B:   coef_b   <= cfg_data;
        REG_COEF_C:   coef_c   <= cfg_data;
        REG_COEF_D:   coef_d   <= cfg_data;
        REG_OFFSET_X: offset_x <= cfg_data;
        REG_OFFSET_Y: offset_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid pipe: input register, product register, result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      prod_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      in_valid   <= accept;
      prod_valid <= in_valid;
      done       <= prod_valid;
    end
  end

  // Capture the point on accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      px <= point.point_x;
      py <= point.point_y;
    end
  end

  // Four exact 32x32 signed products, registered.
  always_ff @(posedge clk) begin
    prod_ax <= px * coef_a;
    prod_by <= py * coef_b;
    prod_cx <= px * coef_c;
    prod_dy <= py * coef_d;
  end

  // Exact sum of both products plus the scaled offset plus half an LSB,
  // then floor shift: this rounds half up in one step.
  always_comb begin
    sum_x = SUM_W'(prod_ax) + SUM_W'(prod_by)
          + (SUM_W'(offset_x) <<< FRAC_BITS) + HALF;
    sum_y = SUM_W'(prod_cx) + SUM_W'(prod_dy)
          + (SUM_W'(offset_y) <<< FRAC_BITS) + HALF;
    shr_x = sum_x >>> FRAC_BITS;
    shr_y = sum_y >>> FRAC_BITS;
    // Out of range when the bits above bit 31 are not all sign copies.
    ovf_x = !((&shr_x[SUM_W-1:DATA_W-1]) || !(|shr_x[SUM_W-1:DATA_W-1]));
    ovf_y = !((&shr_y[SUM_W-1:DATA_W-1]) || !(|shr_y[SUM_W-1:DATA_W-1]));
    sat_x = ovf_x ? (shr_x[SUM_W-1] ? NEG_MAX : POS_MAX) : shr_x[DATA_W-1:0];
    sat_y = ovf_y ? (shr_y[SUM_W-1] ? NEG_MAX : POS_MAX) : shr_y[DATA_W-1:0];
  end

  // Classify the matrix from the config registers.
  always_comb begin
    axis_aligned = (coef_b == '0) && (coef_c == '0);
    rot_90       = !axis_aligned && (coef_a == '0) && (coef_d == '0);
    invalid      = !axis_aligned && !rot_90;
    orient       = '0;
    scale        = 1'b0;
    if (axis_aligned) begin
      orient[0] = coef_a[DATA_W-1];
      orient[1] = coef_d[DATA_W-1];
      scale     = !((coef_a == ONE) || (coef_a == NEG_ONE))
               || !((coef_d == ONE) || (coef_d == NEG_ONE));
    end else if (rot_90) begin
      orient[2] = 1'b1;
      orient[1] = !coef_b[DATA_W-1] && (coef_b != '0);
      orient[0] = coef_c[DATA_W-1];
      scale     = !((coef_b == ONE) || (coef_b == NEG_ONE))
               || !((coef_c == ONE) || (coef_c == NEG_ONE));
    end
    kind = '0;
    if (invalid) begin
      kind[3] = 1'b1;
    end else begin
      // One flip alone reads as scale; two flips read as rotate.
      kind[1] = orient[2] || (orient[1] && orient[0]);
      kind[2] = (orient[0] ^ orient[1]) || scale;
    end
    kind[0] = (offset_x != '0) || (offset_y != '0);
  end

  // Result register.
  always_ff @(posedge clk) begin
    result.mapped_x       <= sat_x;
    result.mapped_y       <= sat_y;
    result.saturated      <= ovf_x || ovf_y;
    result.kind_bits      <= kind;
    result.orient_bits    <= orient;
    result.orient_invalid <= invalid;
    result.needs_filter   <= invalid || kind[3] || kind[2];
  end

endmodule

/* sv/apt_checker.sv */
// Port-level checker for the affine point transform classifier, with its bind.
// Depends on apt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "affine_point_transform_classifier_defines.svh"

module apt_checker
  import apt_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // Every accepted item comes back once it has passed the input, product and
  // result registers, unless reset cleared the pipe in between.
  `APT_ASSERT_ALWAYS(a_done_latency, clk, rst, done == ($past(start && !busy && !rst, 3) && !$past(rst, 2) && !$past(rst, 1)))

  // A skewed matrix reports no orientation and asks for filtering.
  `APT_ASSERT_SAME(a_invalid_fields, clk, rst, done && result.orient_invalid, result.orient_bits == 3'b000 && result.needs_filter && result.kind_bits[3] && !result.kind_bits[1] && !result.kind_bits[2])

  // Unknown is set exactly for an invalid orientation.
  `APT_ASSERT_SAME(a_unknown_match, clk, rst, done, result.kind_bits[3] == result.orient_invalid)

  // A right-angle rotation always carries the rotate kind.
  `APT_ASSERT_SAME(a_rot90_kind, clk, rst, done && result.orient_bits[2], result.kind_bits[1])

endmodule

bind affine_point_transform_classifier apt_checker u_apt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
